>>> hw/rtl/gpps_pkg.sv
// ----------------------------------------------------------------------------
// gpps_pkg
// Shared types and codes for the grid projection path stepper.
// ----------------------------------------------------------------------------
package gpps_pkg;

    localparam int COORD_BITS_DEF = 8;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RANGE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 2'd2;

    localparam logic [7:0] MAX_RANGE_RST  = 8'd20;
    localparam logic [8:0] MAP_WIDTH_RST  = 9'd256;
    localparam logic [8:0] MAP_HEIGHT_RST = 9'd256;

    // input operations
    localparam logic OP_START  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_CELL    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_SAME    = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    // major axis selection
    localparam logic [1:0] AX_VERT = 2'd0;
    localparam logic [1:0] AX_HORZ = 2'd1;
    localparam logic [1:0] AX_DIAG = 2'd2;

    typedef struct packed {
        logic [7:0] max_range;
        logic [8:0] map_width;
        logic [8:0] map_height;
    } cfg_t;

    // input item plus the line setup worked out ahead of the state update
    typedef struct packed {
        logic        op;
        logic [7:0]  x1;
        logic [7:0]  y1;
        logic [7:0]  x2;
        logic [7:0]  y2;
        logic [8:0]  range_limit;
        logic        tunnel;
        logic        stop_occ;
        logic        c_open;
        logic        c_walk;
        logic        c_perm;
        logic        c_occ;
        logic [1:0]  axis;
        logic [1:0]  dirs;
        logic [15:0] half;
        logic [16:0] slope;
    } prep_t;

    typedef struct packed {
        logic [7:0] path_length;
        logic [1:0] status;
        logic [7:0] cell_y;
        logic [7:0] cell_x;
    } result_t;

endpackage

>>> hw/rtl/grid_projection_path_stepper.sv
// ----------------------------------------------------------------------------
// grid_projection_path_stepper
// Steps a line over a grid map one cell at a time, driven by flag reports.
// ----------------------------------------------------------------------------
// Usage:
//   Send a start transaction (s_tuser = 0) with origin, destination, range
//   and mode flags. The result is the first cell of the path (status 0) or
//   a terminal status (1 finished, 2 origin is destination, 3 endpoint off
//   the map). For each cell with status 0, send a report transaction
//   (s_tuser = 1) with that cell's flags; the result is the next cell or
//   status 1. A start at any time abandons the current path.
//   Configuration (max_range, map_width, map_height) is written through
//   cfg_we / cfg_index / cfg_wdata while no transaction is in flight.
// Pipeline:
//   An accepted input is held in the input register (deltas and the two
//   8x8 products are worked out ahead of it); the state update (fraction
//   add, compare and map/range check) is registered in the output register.
//   Throughput is one transaction per cycle while m_tready is high.
// Reset and stall:
//   Reset leaves the block idle with the default configuration. While
//   m_tready is low the result holds and at most one more input is taken
//   into the input register, if it is empty, before s_tready drops.
// ----------------------------------------------------------------------------
module grid_projection_path_stepper #(
    parameter int COORD_BITS = gpps_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x[7:0] start_y[15:8] dest_x[23:16] dest_y[31:24] range_limit[40:32]
    // tunnel_mode[41] stop_at_occupied[42] open_flag[43] cell_walkable[44]
    // cell_permanent[45] cell_occupied[46] zero[47]
    input  logic [gpps_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // op[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cell_x[7:0] cell_y[15:8] path_length[23:16]
    output logic [gpps_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [gpps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [gpps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import gpps_pkg::*;

    cfg_t    cfg_reg;
    prep_t   item;
    result_t result;
    result_t out_reg;
    logic    s1_valid_reg, s1_valid_next;
    logic    m_valid_reg, m_valid_next;
    logic    adv, load, fire, busy;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || adv;
    assign load     = s_tvalid && s_tready;
    assign fire     = s1_valid_reg && adv;

    assign s1_valid_next = load || (s1_valid_reg && !adv);
    assign m_valid_next  = fire || (m_valid_reg && !m_tready);

    gpps_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .clk     (clk),
        .load    (load),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (item)
    );

    gpps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result),
        .busy   (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            cfg_reg.max_range  <= MAX_RANGE_RST;
            cfg_reg.map_width  <= MAP_WIDTH_RST;
            cfg_reg.map_height <= MAP_HEIGHT_RST;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_RANGE:  cfg_reg.max_range  <= cfg_wdata[7:0];
                    CFG_MAP_WIDTH:  cfg_reg.map_width  <= cfg_wdata;
                    CFG_MAP_HEIGHT: cfg_reg.map_height <= cfg_wdata;
                    default:        cfg_reg.max_range  <= cfg_reg.max_range;
                endcase
            end
        end
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.path_length, out_reg.cell_y, out_reg.cell_x};
    assign m_tuser  = out_reg.status;

    a_cell_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_CELL) |-> (m_tdata[23:16] != 8'd0))
        else $error("emitted cell with zero path length");

    a_reject_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_SAME || m_tuser == ST_OUTSIDE))
        |-> (m_tdata == '0))
        else $error("rejected start carries cell or length data");

    a_busy_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ST_CELL) == busy))
        else $error("path state disagrees with pending result status");

endmodule

>>> hw/rtl/gpps_prep.sv
// ----------------------------------------------------------------------------
// gpps_prep
// Input register: unpacks a transaction and precomputes the line setup
// (deltas, directions, major axis, the two products) for a start item.
// ----------------------------------------------------------------------------
module gpps_prep #(
    parameter int COORD_BITS = gpps_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               load,
    input  logic [gpps_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  logic                               s_tuser,
    output gpps_pkg::prep_t                    item
);
    import gpps_pkg::*;

    localparam int         CW    = (COORD_BITS < 8) ? COORD_BITS : 8;
    localparam logic [7:0] CMASK = 8'((1 << CW) - 1);

    prep_t      item_reg;
    prep_t      item_next;
    logic [7:0] x1, y1, x2, y2;
    logic [7:0] ax, ay, minor_d;
    logic       x_neg, y_neg;
    logic [15:0] prod_xy, prod_sq;

    assign x1 = s_tdata[7:0]   & CMASK;
    assign y1 = s_tdata[15:8]  & CMASK;
    assign x2 = s_tdata[23:16] & CMASK;
    assign y2 = s_tdata[31:24] & CMASK;

    assign x_neg   = x2 < x1;
    assign y_neg   = y2 < y1;
    assign ax      = x_neg ? (x1 - x2) : (x2 - x1);
    assign ay      = y_neg ? (y1 - y2) : (y2 - y1);
    assign minor_d = (ay > ax) ? ax : ay;
    assign prod_xy = {8'd0, ax} * {8'd0, ay};
    assign prod_sq = {8'd0, minor_d} * {8'd0, minor_d};

    always_comb
    begin
        item_next             = '0;
        item_next.op          = s_tuser;
        item_next.x1          = x1;
        item_next.y1          = y1;
        item_next.x2          = x2;
        item_next.y2          = y2;
        item_next.range_limit = s_tdata[40:32];
        item_next.tunnel      = s_tdata[41];
        item_next.stop_occ    = s_tdata[42];
        item_next.c_open      = s_tdata[43];
        item_next.c_walk      = s_tdata[44];
        item_next.c_perm      = s_tdata[45];
        item_next.c_occ       = s_tdata[46];
        item_next.dirs        = {y_neg, x_neg};
        item_next.half        = prod_xy;
        if (ay > ax)
        begin
            item_next.axis  = AX_VERT;
            item_next.slope = {prod_sq, 1'b0};
        end
        else if (ax > ay)
        begin
            item_next.axis  = AX_HORZ;
            item_next.slope = {prod_sq, 1'b0};
        end
        else
        begin
            item_next.axis  = AX_DIAG;
            item_next.slope = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

>>> hw/rtl/gpps_core.sv
// ----------------------------------------------------------------------------
// gpps_core
// Path state and single-pass step: start setup, flag report decision,
// one fractional line step and the range / map check before each emit.
// ----------------------------------------------------------------------------
module gpps_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  gpps_pkg::prep_t   item,
    input  gpps_pkg::cfg_t    cfg,
    output gpps_pkg::result_t result,
    output logic              busy
);
    import gpps_pkg::*;

    logic signed [9:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [7:0]         target_x_reg, target_x_next, target_y_reg, target_y_next;
    logic [1:0]         dirs_reg, dirs_next, axis_reg, axis_next;
    logic signed [19:0] frac_reg, frac_next;
    logic [16:0]        slope_reg, slope_next;
    logic [15:0]        half_reg, half_next;
    logic [7:0]         major_reg, major_next, minor_reg, minor_next;
    logic [7:0]         range_reg, range_next;
    logic [1:0]         mode_reg, mode_next;
    logic [7:0]         length_reg, length_next;
    logic               busy_reg, busy_next;

    logic               is_start, start_in, same_pt, stop_hit, do_step;
    logic [7:0]         eff_range;
    logic [1:0]         axis_u, dirs_u;
    logic [16:0]        slope_u;
    logic [15:0]        half_u;
    logic signed [19:0] frac_base, frac_sum, frac_wrap;
    logic signed [9:0]  base_x, base_y, step_x, step_y;
    logic [7:0]         minor_base, major_base, range_u, len_base;
    logic               move;
    logic signed [9:0]  nx, ny;
    logic signed [19:0] nf;
    logic [7:0]         nminor;
    logic [8:0]         used;
    logic               emit_ok;

    function automatic logic in_map(input logic signed [9:0] x, input logic signed [9:0] y,
                                    input cfg_t c);
        return !x[9] && !y[9] && (x[8:0] < c.map_width) && (y[8:0] < c.map_height);
    endfunction

    assign is_start  = (item.op == OP_START);
    assign start_in  = in_map({2'b00, item.x1}, {2'b00, item.y1}, cfg)
                    && in_map({2'b00, item.x2}, {2'b00, item.y2}, cfg);
    assign same_pt   = (item.x1 == item.x2) && (item.y1 == item.y2);
    assign eff_range = item.range_limit[8] ? cfg.max_range : item.range_limit[7:0];

    assign stop_hit = (mode_reg[0] ? item.c_perm : !(item.c_open | item.c_walk))
                   || (mode_reg[1] && item.c_occ)
                   || (cur_x_reg == $signed({2'b00, target_x_reg})
                       && cur_y_reg == $signed({2'b00, target_y_reg}));

    assign do_step = is_start ? (start_in && !same_pt) : (busy_reg && !stop_hit);

    // a start steps from the origin with a fresh line, a report from the current cell
    assign axis_u     = is_start ? item.axis  : axis_reg;
    assign dirs_u     = is_start ? item.dirs  : dirs_reg;
    assign slope_u    = is_start ? item.slope : slope_reg;
    assign half_u     = is_start ? item.half  : half_reg;
    assign frac_base  = is_start ? 20'sd0     : frac_reg;
    assign base_x     = is_start ? $signed({2'b00, item.x1}) : cur_x_reg;
    assign base_y     = is_start ? $signed({2'b00, item.y1}) : cur_y_reg;
    assign minor_base = is_start ? 8'd0 : minor_reg;
    assign major_base = is_start ? 8'd0 : major_reg;
    assign range_u    = is_start ? eff_range : range_reg;
    assign len_base   = is_start ? 8'd0 : length_reg;

    assign step_x = dirs_u[0] ? -10'sd1 : 10'sd1;
    assign step_y = dirs_u[1] ? -10'sd1 : 10'sd1;

    assign frac_sum  = frac_base + $signed({3'b000, slope_u});
    assign frac_wrap = frac_sum - $signed({3'b000, half_u, 1'b0});
    assign move      = (is_start || slope_u != 17'd0)
                    && (frac_sum > $signed({4'b0000, half_u}));

    always_comb
    begin
        nx     = base_x;
        ny     = base_y;
        nf     = frac_base;
        nminor = minor_base;
        case (axis_u)
            AX_DIAG:
            begin
                nx = base_x + step_x;
                ny = base_y + step_y;
            end
            AX_VERT:
            begin
                ny     = base_y + step_y;
                nx     = move ? (base_x + step_x) : base_x;
                nf     = move ? frac_wrap : frac_sum;
                nminor = minor_base + {7'd0, move};
            end
            AX_HORZ:
            begin
                nx     = base_x + step_x;
                ny     = move ? (base_y + step_y) : base_y;
                nf     = move ? frac_wrap : frac_sum;
                nminor = minor_base + {7'd0, move};
            end
            default:
            begin
                nx = base_x;
            end
        endcase
    end

    assign used = (axis_u == AX_DIAG) ? ({1'b0, major_base} + {2'b00, major_base[7:1]})
                                      : ({1'b0, major_base} + {2'b00, nminor[7:1]});
    assign emit_ok = (used < {1'b0, range_u}) && in_map(nx, ny, cfg);

    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        dirs_next     = dirs_reg;
        axis_next     = axis_reg;
        frac_next     = frac_reg;
        slope_next    = slope_reg;
        half_next     = half_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        range_next    = range_reg;
        mode_next     = mode_reg;
        length_next   = len_base;
        busy_next     = 1'b0;

        result             = '0;
        result.status      = ST_DONE;
        result.path_length = len_base;

        if (is_start)
        begin
            if (!start_in)
            begin
                result.status = ST_OUTSIDE;
            end
            else if (same_pt)
            begin
                result.status = ST_SAME;
            end
            else
            begin
                range_next    = eff_range;
                mode_next     = {item.stop_occ, item.tunnel};
                target_x_next = item.x2;
                target_y_next = item.y2;
                dirs_next     = item.dirs;
                axis_next     = item.axis;
                half_next     = item.half;
                slope_next    = item.slope;
            end
        end

        if (do_step)
        begin
            cur_x_next = nx;
            cur_y_next = ny;
            frac_next  = nf;
            minor_next = nminor;
            major_next = major_base;
            if (emit_ok)
            begin
                major_next         = major_base + 8'd1;
                length_next        = len_base + 8'd1;
                busy_next          = 1'b1;
                result.cell_x      = nx[7:0];
                result.cell_y      = ny[7:0];
                result.status      = ST_CELL;
                result.path_length = len_base + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            dirs_reg     <= '0;
            axis_reg     <= AX_VERT;
            frac_reg     <= '0;
            slope_reg    <= '0;
            half_reg     <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            range_reg    <= '0;
            mode_reg     <= '0;
            length_reg   <= '0;
            busy_reg     <= 1'b0;
        end
        else if (fire)
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            dirs_reg     <= dirs_next;
            axis_reg     <= axis_next;
            frac_reg     <= frac_next;
            slope_reg    <= slope_next;
            half_reg     <= half_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            range_reg    <= range_next;
            mode_reg     <= mode_next;
            length_reg   <= length_next;
            busy_reg     <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_projection_path_stepper testbench
// Drives start and flag-report transactions into the path stepper and checks
// every result against a cycle-free line-walk predictor or a fixed result.
// A short directed list covers the corner cases, then random paths run under
// several map and range settings with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    import gpps_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int NUM_SEGS    = 6;

    typedef struct packed {
        logic       op;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [8:0] rng;
        logic       tun;
        logic       stp;
        logic       c_open;
        logic       c_walk;
        logic       c_perm;
        logic       c_occ;
    } path_item_t;

    typedef struct packed {
        path_item_t item;
        logic       known;
        result_t    want;
        logic       remap;
    } directed_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic [1:0]                m_tuser;
    logic                      cfg_we;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    grid_projection_path_stepper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // line walker state, mirrors the block
    int         mr_cfg  = 20;
    int         w_cfg   = 256;
    int         h_cfg   = 256;
    int         cx      = 0;
    int         cy      = 0;
    int         tx      = 0;
    int         ty      = 0;
    logic [1:0] dirs    = '0;
    logic [1:0] axis    = AX_VERT;
    int         frac    = 0;
    int         slope_v = 0;
    int         half_v  = 0;
    int         major_n = 0;
    int         minor_n = 0;
    int         range_v = 0;
    logic [1:0] modes   = '0;
    logic [7:0] len_n   = '0;
    bit         walking = 1'b0;

    result_t       pending_results[$];
    directed_row_t directed_rows[$];

    int src_idle;
    int dst_idle;
    int fail_count  = 0;
    int idle_cycles = 0;
    int n_sent      = 0;
    int n_starts    = 0;
    int n_cells     = 0;
    int n_checked   = 0;

    int seg_mr[NUM_SEGS]    = '{255, 1, 7, 100, 50, 20};
    int seg_w[NUM_SEGS]     = '{256, 256, 1, 256, 37, 256};
    int seg_h[NUM_SEGS]     = '{256, 256, 256, 1, 200, 256};
    int seg_src[NUM_SEGS]   = '{25, 25, 25, 77, 77, 0};
    int seg_dst[NUM_SEGS]   = '{77, 77, 77, 25, 25, 0};
    int seg_items[NUM_SEGS] = '{120, 40, 40, 40, 120, 140};

    function automatic result_t path_result(int x, int y, logic [1:0] st, logic [7:0] len);
        result_t r;
        r.cell_x      = x[7:0];
        r.cell_y      = y[7:0];
        r.status      = st;
        r.path_length = len;
        return r;
    endfunction

    function automatic bit on_map(int x, int y);
        return x >= 0 && y >= 0 && x < w_cfg && y < h_cfg;
    endfunction

    function automatic bit take_minor();
        if (frac > half_v)
        begin
            frac -= 2 * half_v;
            minor_n++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t emit_next();
        int used;
        if (axis == AX_DIAG)
            used = major_n + (major_n >> 1);
        else
            used = major_n + (minor_n >> 1);
        if (used >= range_v || !on_map(cx, cy))
        begin
            walking = 1'b0;
            return path_result(0, 0, ST_DONE, len_n);
        end
        major_n++;
        len_n   = len_n + 8'd1;
        walking = 1'b1;
        return path_result(cx, cy, ST_CELL, len_n);
    endfunction

    function automatic void step_line();
        int sx;
        int sy;
        sx = dirs[0] ? -1 : 1;
        sy = dirs[1] ? -1 : 1;
        if (axis == AX_DIAG)
        begin
            cx += sx;
            cy += sy;
        end
        else if (axis == AX_VERT)
        begin
            if (slope_v != 0)
            begin
                frac += slope_v;
                if (take_minor())
                    cx += sx;
            end
            cy += sy;
        end
        else
        begin
            if (slope_v != 0)
            begin
                frac += slope_v;
                if (take_minor())
                    cy += sy;
            end
            cx += sx;
        end
    endfunction

    function automatic result_t predict_step(path_item_t it);
        int x1;
        int y1;
        int x2;
        int y2;
        int ax;
        int ay;
        int sx;
        int sy;
        bit halt;
        if (it.op == OP_REPORT)
        begin
            if (!walking)
                return path_result(0, 0, ST_DONE, len_n);
            if (modes[0])
                halt = it.c_perm;
            else
                halt = !(it.c_open || it.c_walk);
            if (modes[1] && it.c_occ)
                halt = 1'b1;
            if (cx == tx && cy == ty)
                halt = 1'b1;
            if (halt)
            begin
                walking = 1'b0;
                return path_result(0, 0, ST_DONE, len_n);
            end
            step_line();
            return emit_next();
        end
        x1 = int'(it.sx);
        y1 = int'(it.sy);
        x2 = int'(it.dx);
        y2 = int'(it.dy);
        walking = 1'b0;
        len_n   = '0;
        if (!on_map(x1, y1) || !on_map(x2, y2))
            return path_result(0, 0, ST_OUTSIDE, len_n);
        if (x1 == x2 && y1 == y2)
            return path_result(0, 0, ST_SAME, len_n);
        range_v = it.rng[8] ? mr_cfg : int'(it.rng[7:0]);
        modes   = {it.stp, it.tun};
        tx      = x2;
        ty      = y2;
        sx      = (x2 < x1) ? -1 : 1;
        sy      = (y2 < y1) ? -1 : 1;
        ax      = (x2 < x1) ? x1 - x2 : x2 - x1;
        ay      = (y2 < y1) ? y1 - y2 : y2 - y1;
        dirs    = {y2 < y1, x2 < x1};
        half_v  = ax * ay;
        major_n = 0;
        minor_n = 0;
        if (ay > ax)
        begin
            axis    = AX_VERT;
            slope_v = ax * ax * 2;
            cy      = y1 + sy;
            cx      = x1;
            frac    = slope_v;
            if (take_minor())
                cx += sx;
        end
        else if (ax > ay)
        begin
            axis    = AX_HORZ;
            slope_v = ay * ay * 2;
            cx      = x1 + sx;
            cy      = y1;
            frac    = slope_v;
            if (take_minor())
                cy += sy;
        end
        else
        begin
            axis    = AX_DIAG;
            slope_v = 0;
            frac    = 0;
            cx      = x1 + sx;
            cy      = y1 + sy;
        end
        return emit_next();
    endfunction

    function automatic path_item_t start_of(int sx, int sy, int dx, int dy,
                                            logic [8:0] rng, logic tun, logic stp);
        path_item_t it;
        it     = '0;
        it.op  = OP_START;
        it.sx  = sx[7:0];
        it.sy  = sy[7:0];
        it.dx  = dx[7:0];
        it.dy  = dy[7:0];
        it.rng = rng;
        it.tun = tun;
        it.stp = stp;
        return it;
    endfunction

    function automatic path_item_t report_of(logic c_open, logic c_walk,
                                             logic c_perm, logic c_occ);
        path_item_t it;
        it        = '0;
        it.op     = OP_REPORT;
        it.c_open = c_open;
        it.c_walk = c_walk;
        it.c_perm = c_perm;
        it.c_occ  = c_occ;
        return it;
    endfunction

    function automatic logic [7:0] map_coord(int lim);
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, lim - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] near_coord(logic [7:0] c);
        int d;
        d = int'(c) + int'($urandom_range(0, 24)) - 12;
        if (d < 0)
            d = 0;
        if (d > 255)
            d = 255;
        return d[7:0];
    endfunction

    // mostly well-formed: reports follow emitted cells, starts follow idle
    function automatic path_item_t pick_item();
        path_item_t it;
        int roll;
        int lim_w;
        int lim_h;
        it    = path_item_t'(48'({$urandom, $urandom}));
        roll  = int'($urandom_range(0, 99));
        lim_w = (w_cfg > 256) ? 256 : w_cfg;
        lim_h = (h_cfg > 256) ? 256 : h_cfg;
        if ((walking && roll < 88) || (!walking && roll < 8))
        begin
            it.op     = OP_REPORT;
            it.c_open = ($urandom_range(0, 99) < 75);
            it.c_walk = 1'($urandom_range(0, 1));
            it.c_perm = ($urandom_range(0, 99) < 15);
            it.c_occ  = ($urandom_range(0, 99) < 20);
        end
        else
        begin
            it.op = OP_START;
            it.sx = map_coord(lim_w);
            it.sy = map_coord(lim_h);
            if ($urandom_range(0, 1) != 0)
            begin
                it.dx = near_coord(it.sx);
                it.dy = near_coord(it.sy);
            end
            else
            begin
                it.dx = map_coord(lim_w);
                it.dy = map_coord(lim_h);
            end
            roll = int'($urandom_range(0, 99));
            if (roll < 10)
                it.rng = {1'b1, 8'($urandom_range(0, 255))};
            else if (roll < 15)
                it.rng = 9'd0;
            else if (roll < 25)
                it.rng = 9'd255;
            else
                it.rng = 9'($urandom_range(1, 60));
        end
        return it;
    endfunction

    task automatic add_row(input path_item_t it, input logic known, input result_t want,
                           input logic remap);
        directed_row_t row;
        row.item  = it;
        row.known = known;
        row.want  = want;
        row.remap = remap;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input path_item_t it, input logic known, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {1'b0, it.c_occ, it.c_perm, it.c_walk, it.c_open, it.stp, it.tun,
                     it.rng, it.dy, it.dx, it.sy, it.sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_step(it);
        pending_results.push_back(known ? want : predicted);
        n_sent++;
        if (it.op == OP_START)
            n_starts++;
        if (predicted.status == ST_CELL)
            n_cells++;
        @(negedge clk);
    endtask

    // hold the input side until every result is back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[8:0];
        case (idx)
            CFG_MAX_RANGE:  mr_cfg = val & 'hFF;
            CFG_MAP_WIDTH:  w_cfg  = val & 'h1FF;
            CFG_MAP_HEIGHT: h_cfg  = val & 'h1FF;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= dst_idle);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: cell_x %0d cell_y %0d status %0d path_length %0d",
                       m_tdata[7:0], m_tdata[15:8], m_tuser, m_tdata[23:16]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_tdata[7:0] !== want.cell_x)
                begin
                    $error("cell_x: expected %0d, got %0d", want.cell_x, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.cell_y)
                begin
                    $error("cell_y: expected %0d, got %0d", want.cell_y, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[23:16] !== want.path_length)
                begin
                    $error("path_length: expected %0d, got %0d", want.path_length,
                           m_tdata[23:16]);
                    fail_count++;
                end
            end
        end
    end

    // end the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("grid_projection_path_stepper test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        src_idle  = 25;
        dst_idle  = 77;

        // reset defaults: 256 x 256 map, max_range 20
        add_row(report_of(1'b1, 1'b1, 1'b1, 1'b1), 1'b1,
                path_result(0, 0, ST_DONE, 8'd0), 1'b0);
        add_row(start_of(10, 10, 10, 10, 9'd5, 1'b0, 1'b0), 1'b1,
                path_result(0, 0, ST_SAME, 8'd0), 1'b0);
        add_row(start_of(0, 0, 255, 255, 9'h1FF, 1'b0, 1'b0), 1'b1,
                path_result(1, 1, ST_CELL, 8'd1), 1'b0);
        add_row(report_of(1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b0, 1'b1, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(start_of(255, 0, 0, 255, 9'd0, 1'b1, 1'b1), 1'b1,
                path_result(0, 0, ST_DONE, 8'd0), 1'b0);
        add_row(start_of(5, 5, 5, 200, 9'd255, 1'b1, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b0, 1'b0, 1'b0, 1'b1), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b1, 1'b1, 1'b0), 1'b0, '0, 1'b0);
        add_row(start_of(200, 100, 10, 90, 9'd255, 1'b0, 1'b1), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b0, 1'b0, 1'b1), 1'b0, '0, 1'b0);
        add_row(start_of(3, 3, 5, 4, 9'd255, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(start_of(100, 100, 120, 130, 9'd255, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        // start while busy drops the old path
        add_row(start_of(0, 255, 255, 0, 9'd255, 1'b1, 1'b1), 1'b0, '0, 1'b0);
        add_row(report_of(1'b1, 1'b1, 1'b1, 1'b1), 1'b0, '0, 1'b0);
        // from here on a 200 x 180 map
        add_row(start_of(199, 179, 0, 0, 9'd1, 1'b0, 1'b0), 1'b0, '0, 1'b1);
        add_row(report_of(1'b1, 1'b1, 1'b0, 1'b0), 1'b0, '0, 1'b0);
        add_row(start_of(200, 10, 5, 5, 9'd255, 1'b0, 1'b0), 1'b1,
                path_result(0, 0, ST_OUTSIDE, 8'd0), 1'b0);
        add_row(start_of(5, 5, 5, 180, 9'd255, 1'b0, 1'b0), 1'b1,
                path_result(0, 0, ST_OUTSIDE, 8'd0), 1'b0);
        add_row(start_of(190, 170, 199, 179, 9'h100, 1'b0, 1'b0), 1'b0, '0, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].remap)
            begin
                settle();
                write_reg(CFG_MAP_WIDTH, 200);
                write_reg(CFG_MAP_HEIGHT, 180);
            end
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
        end

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            settle();
            write_reg(CFG_MAX_RANGE, seg_mr[seg]);
            write_reg(CFG_MAP_WIDTH, seg_w[seg]);
            write_reg(CFG_MAP_HEIGHT, seg_h[seg]);
            src_idle = seg_src[seg];
            dst_idle = seg_dst[seg];
            repeat (seg_items[seg])
                send_item(pick_item(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("covered %0d transactions: %0d path starts, %0d cells stepped",
                 n_sent, n_starts, n_cells);
        $display("checked %0d results over %0d map/range settings, %0d mismatches",
                 n_checked, NUM_SEGS + 2, fail_count);
        if (fail_count == 0)
            $display("grid_projection_path_stepper test passed");
        else
            $display("grid_projection_path_stepper test failed");
        $finish;
    end

endmodule

>>> grid_projection_path_stepper.f
hw/rtl/gpps_pkg.sv
hw/rtl/gpps_prep.sv
hw/rtl/gpps_core.sv
hw/rtl/grid_projection_path_stepper.sv
sim/testbench.sv
